// ===== hw/rtl/qte_pkg.sv =====
`timescale 1ns / 1ps
package qte_pkg;
    localparam int CordicStagesDefault  = 16;
    localparam int ComponentBitsDefault = 16;
    localparam int TableLen   = 24;
    localparam int AngleBits  = 16;
    localparam int ZBits      = 36;
    localparam logic signed [ZBits-1:0] QuarterTurn = 36'sd1073741824;

    // atan(2^-i) in units of pi / 2^31
    function automatic logic signed [ZBits-1:0] atan_entry(input int idx);
        logic [31:0] v;
        begin
            unique case (idx)
                0: v = 32'h20000000;  1: v = 32'h12E4051E;  2: v = 32'h09FB385B;
                3: v = 32'h051111D4;  4: v = 32'h028B0D43;  5: v = 32'h0145D7E1;
                6: v = 32'h00A2F61E;  7: v = 32'h00517C55;  8: v = 32'h0028BE53;
                9: v = 32'h00145F2F; 10: v = 32'h000A2F98; 11: v = 32'h000517CC;
                12: v = 32'h00028BE6; 13: v = 32'h000145F3; 14: v = 32'h0000A2FA;
                15: v = 32'h0000517D; 16: v = 32'h000028BE; 17: v = 32'h0000145F;
                18: v = 32'h00000A30; 19: v = 32'h00000518; 20: v = 32'h0000028C;
                21: v = 32'h00000146; 22: v = 32'h000000A3; 23: v = 32'h00000051;
                default: v = 32'h0;
            endcase
            atan_entry = ZBits'(signed'({1'b0, v}));
        end
    endfunction

    // round half up to a 16-bit binary angle
    function automatic logic signed [AngleBits-1:0] to_bam(input logic signed [ZBits-1:0] z);
        logic signed [ZBits-1:0] t;
        begin
            t = z + ZBits'(32768);
            to_bam = t[16 +: AngleBits];
        end
    endfunction
endpackage

// ===== hw/rtl/qte_stream_if.sv =====
`timescale 1ns / 1ps
interface qte_stream_if #(parameter int W = 64);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/qte_cordic_cell.sv =====
`timescale 1ns / 1ps
// One vectoring CORDIC micro-rotation; registered, advances when i_en.
module qte_cordic_cell #(
    parameter int XW  = 64,
    parameter int IDX = 0
) (
    input  logic                               i_clk,
    input  logic                               i_en,
    input  logic signed [XW-1:0]               i_x,
    input  logic signed [XW-1:0]               i_y,
    input  logic signed [qte_pkg::ZBits-1:0]   i_z,
    output logic signed [XW-1:0]               o_x,
    output logic signed [XW-1:0]               o_y,
    output logic signed [qte_pkg::ZBits-1:0]   o_z
);
    logic signed [XW-1:0] dx, dy;
    logic signed [XW-1:0] r_x, r_y;
    logic signed [qte_pkg::ZBits-1:0] r_z;

    // arithmetic shift is floor division
    assign dx = i_y >>> IDX;
    assign dy = i_x >>> IDX;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (!i_y[XW-1]) begin
                r_x <= i_x + dx;
                r_y <= i_y - dy;
                r_z <= i_z + qte_pkg::atan_entry(IDX);
            end else begin
                r_x <= i_x - dx;
                r_y <= i_y + dy;
                r_z <= i_z - qte_pkg::atan_entry(IDX);
            end
        end
    end

    assign o_x = r_x;
    assign o_y = r_y;
    assign o_z = r_z;
endmodule

// ===== hw/rtl/qte_cordic_row.sv =====
`timescale 1ns / 1ps
// Quadrant pre-turn register, then a row of registered CORDIC cells.
module qte_cordic_row #(
    parameter int XW     = 64,
    parameter int STAGES = 16
) (
    input  logic                             i_clk,
    input  logic                             i_en,
    input  logic signed [XW-1:0]             i_y,
    input  logic signed [XW-1:0]             i_x,
    output logic signed [qte_pkg::ZBits-1:0] o_z
);
    logic signed [XW-1:0] cx [STAGES+1];
    logic signed [XW-1:0] cy [STAGES+1];
    logic signed [qte_pkg::ZBits-1:0] cz [STAGES+1];
    logic signed [XW-1:0] r_x, r_y;
    logic signed [qte_pkg::ZBits-1:0] r_z;
    logic r_zero;
    logic [STAGES-1:0] r_zero_d;

    // quarter turn for negative x
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_zero <= (i_x == '0) && (i_y == '0);
            if (i_x[XW-1] && !i_y[XW-1]) begin
                r_x <= i_y;  r_y <= -i_x;  r_z <= qte_pkg::QuarterTurn;
            end else if (i_x[XW-1]) begin
                r_x <= -i_y; r_y <= i_x;   r_z <= -qte_pkg::QuarterTurn;
            end else begin
                r_x <= i_x;  r_y <= i_y;   r_z <= '0;
            end
        end
    end

    assign cx[0] = r_x;
    assign cy[0] = r_y;
    assign cz[0] = r_z;

    for (genvar g = 0; g < STAGES; g++) begin : g_cell
        qte_cordic_cell #(.XW(XW), .IDX(g)) u_cell (
            .i_clk(i_clk), .i_en(i_en),
            .i_x(cx[g]), .i_y(cy[g]), .i_z(cz[g]),
            .o_x(cx[g+1]), .o_y(cy[g+1]), .o_z(cz[g+1])
        );
    end

    // zero vector flag follows the row
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_zero_d <= {r_zero_d[STAGES-2:0], r_zero};
        end
    end

    assign o_z = r_zero_d[STAGES-1] ? '0 : cz[STAGES];
endmodule

// ===== hw/rtl/quaternion_to_euler_angles.sv =====
`timescale 1ns / 1ps
// Quaternion (w,x,y,z, signed Q1.15) to ZYX Euler angles as 16-bit binary
// angles (32768 = pi). Fully pipelined: one beat per cycle while the output
// is not held. Registered steps in order: product, sum, square, 1 - s^2,
// one cell per square-root result bit (31 at the default width), pre-turn,
// one register per CORDIC cell, output. The pipeline stalls as a whole when
// the output is held; the clamp flag in bit 48 marks |sin(pitch)| >= 1.
module quaternion_to_euler_angles #(
    parameter int CORDIC_STAGES  = qte_pkg::CordicStagesDefault,
    parameter int COMPONENT_BITS = qte_pkg::ComponentBitsDefault
) (
    input  logic i_clk,
    input  logic i_rst_n,
    qte_stream_if.sink   i_quat,
    qte_stream_if.source o_euler
);
    localparam int CB   = COMPONENT_BITS;
    localparam int FB   = CB - 1;
    localparam int PS   = (2 * FB > 58) ? (2 * FB - 58) : 0;
    localparam int SF   = 2 * FB - PS;
    localparam int AF   = (SF > 30) ? 30 : SF;
    localparam int NS   = (CORDIC_STAGES > qte_pkg::TableLen) ? qte_pkg::TableLen
                                                              : CORDIC_STAGES;
    localparam int PW   = 2 * CB - PS + 1;
    localparam int XW   = SF + 6;
    localparam int SQB  = AF + 2;
    // product, sum, square, 1 - s^2, AF+1 root cells, pre-turn, NS cells, output
    localparam int LAT  = NS + AF + 7;
    localparam int AW   = qte_pkg::AngleBits;

    logic en;
    logic signed [CB-1:0] qw, qx, qy, qz;
    logic [LAT-1:0] r_vld;

    assign en = !o_euler.valid || o_euler.ready;
    assign i_quat.ready = en;
    assign qw = i_quat.data[0*CB +: CB];
    assign qx = i_quat.data[1*CB +: CB];
    assign qy = i_quat.data[2*CB +: CB];
    assign qz = i_quat.data[3*CB +: CB];

    // valid pipe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[LAT-2:0], i_quat.valid};
        end
    end

    // stage 1: products
    logic signed [PW-1:0] r_wx, r_yz, r_xx, r_yy, r_wy, r_zx, r_wz, r_xy, r_zz;
    function automatic logic signed [PW-1:0] pr(input logic signed [CB-1:0] a,
                                                input logic signed [CB-1:0] b);
        logic signed [2*CB-1:0] p;
        begin
            p = a * b;
            pr = PW'(p >>> PS);
        end
    endfunction
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_wx <= pr(qw, qx); r_yz <= pr(qy, qz); r_xx <= pr(qx, qx);
            r_yy <= pr(qy, qy); r_wy <= pr(qw, qy); r_zx <= pr(qz, qx);
            r_wz <= pr(qw, qz); r_xy <= pr(qx, qy); r_zz <= pr(qz, qz);
        end
    end

    // stage 2: product sums
    logic signed [XW-1:0] r_sr, r_cr, r_sp, r_sy, r_cy, one;
    assign one = XW'(1) <<< SF;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sr <= (XW'(r_wx) + XW'(r_yz)) <<< 1;
            r_cr <= one - ((XW'(r_xx) + XW'(r_yy)) <<< 1);
            r_sp <= (XW'(r_wy) - XW'(r_zx)) <<< 1;
            r_sy <= (XW'(r_wz) + XW'(r_xy)) <<< 1;
            r_cy <= one - ((XW'(r_yy) + XW'(r_zz)) <<< 1);
        end
    end

    // stage 3: pitch sine, clamp test, square
    logic signed [XW-1:0] se_c;
    logic [AF:0] mag_c;
    logic signed [XW-1:0] r_se;
    logic [2*AF+1:0] r_sq;
    logic r_clamp, r_neg;
    assign se_c = r_sp >>> (SF - AF);
    assign mag_c = se_c[XW-1] ? (AF+1)'(-se_c) : (AF+1)'(se_c);
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_se    <= se_c;
            r_sq    <= mag_c * mag_c;
            r_clamp <= (r_sp >= one) || (r_sp <= -one);
            r_neg   <= r_sp[XW-1];
        end
    end

    // stage 4: 1 - s^2, then pipelined square root (one cell per result bit)
    localparam int RB = AF + 1;
    logic [2*AF+1:0] rem_c;
    assign rem_c = (r_sq >= ((2*AF+2)'(1) << (2*AF))) ? '0
                 : ((2*AF+2)'(1) << (2*AF)) - r_sq;

    logic [2*AF+3:0] s_n [RB+1];
    logic [2*AF+3:0] s_r [RB+1];
    logic signed [XW-1:0] s_se [RB+1];
    logic s_cl [RB+1];
    logic s_ng [RB+1];
    logic [2*AF+3:0] r_n0;
    logic signed [XW-1:0] r_se0;
    logic r_cl0, r_ng0;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_n0 <= (2*AF+4)'(rem_c); r_se0 <= r_se; r_cl0 <= r_clamp; r_ng0 <= r_neg;
        end
    end
    assign s_n[0] = r_n0; assign s_r[0] = '0; assign s_se[0] = r_se0;
    assign s_cl[0] = r_cl0; assign s_ng[0] = r_ng0;
    for (genvar g = 0; g < RB; g++) begin : g_sqrt
        localparam logic [2*AF+3:0] BIT = (2*AF+4)'(1) << (2*(RB-1-g));
        logic [2*AF+3:0] r_n, r_r;
        logic signed [XW-1:0] r_s;
        logic r_c, r_g;
        always_ff @(posedge i_clk) begin
            if (en) begin
                if (s_n[g] >= s_r[g] + BIT) begin
                    r_n <= s_n[g] - (s_r[g] + BIT);
                    r_r <= (s_r[g] >> 1) + BIT;
                end else begin
                    r_n <= s_n[g];
                    r_r <= s_r[g] >> 1;
                end
                r_s <= s_se[g]; r_c <= s_cl[g]; r_g <= s_ng[g];
            end
        end
        assign s_n[g+1] = r_n; assign s_r[g+1] = r_r; assign s_se[g+1] = r_s;
        assign s_cl[g+1] = r_c; assign s_ng[g+1] = r_g;
    end

    // roll/yaw inputs delayed to line up with the pitch path
    localparam int DL = RB + 2;
    logic signed [XW-1:0] d_sr [DL+1], d_cr [DL+1], d_sy [DL+1], d_cy [DL+1];
    assign d_sr[0] = r_sr; assign d_cr[0] = r_cr;
    assign d_sy[0] = r_sy; assign d_cy[0] = r_cy;
    for (genvar g = 0; g < DL; g++) begin : g_dly
        logic signed [XW-1:0] a, b, c, d;
        always_ff @(posedge i_clk) begin
            if (en) begin
                a <= d_sr[g]; b <= d_cr[g]; c <= d_sy[g]; d <= d_cy[g];
            end
        end
        assign d_sr[g+1] = a; assign d_cr[g+1] = b;
        assign d_sy[g+1] = c; assign d_cy[g+1] = d;
    end

    logic signed [qte_pkg::ZBits-1:0] z_roll, z_pitch, z_yaw;
    qte_cordic_row #(.XW(XW), .STAGES(NS)) u_roll (
        .i_clk(i_clk), .i_en(en), .i_y(d_sr[DL]), .i_x(d_cr[DL]), .o_z(z_roll));
    qte_cordic_row #(.XW(XW), .STAGES(NS)) u_pitch (
        .i_clk(i_clk), .i_en(en), .i_y(s_se[RB]), .i_x(XW'(s_r[RB])), .o_z(z_pitch));
    qte_cordic_row #(.XW(XW), .STAGES(NS)) u_yaw (
        .i_clk(i_clk), .i_en(en), .i_y(d_sy[DL]), .i_x(d_cy[DL]), .o_z(z_yaw));

    // clamp flag and sign follow the CORDIC row
    logic [NS:0] r_cl_d, r_ng_d;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_cl_d <= {r_cl_d[NS-1:0], s_cl[RB]};
            r_ng_d <= {r_ng_d[NS-1:0], s_ng[RB]};
        end
    end

    // output register
    logic signed [AW-1:0] r_roll, r_pitch, r_yaw, p_c;
    logic r_pcl;
    logic signed [qte_pkg::ZBits-1:0] pt;
    assign pt = z_pitch + qte_pkg::ZBits'(32768);
    always_comb begin
        if (r_cl_d[NS]) begin
            p_c = r_ng_d[NS] ? -AW'(16384) : AW'(16384);
        end else if ($signed(pt[qte_pkg::ZBits-1:16])
                     > $signed((qte_pkg::ZBits-16)'(16384))) begin
            p_c = AW'(16384);
        end else if ($signed(pt[qte_pkg::ZBits-1:16])
                     < -$signed((qte_pkg::ZBits-16)'(16384))) begin
            p_c = -AW'(16384);
        end else begin
            p_c = qte_pkg::to_bam(z_pitch);
        end
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_roll  <= qte_pkg::to_bam(z_roll);
            r_yaw   <= qte_pkg::to_bam(z_yaw);
            r_pitch <= p_c;
            r_pcl   <= r_cl_d[NS];
        end
    end

    assign o_euler.valid = r_vld[LAT-1];
    assign o_euler.data  = 64'({r_pcl, r_yaw, r_pitch, r_roll});
endmodule
